// ===== hdl/rgsd_pkg.sv =====
// rgsd_pkg: shared types and constants of the run-length glyph span decoder
// used by rgsd_front, rgsd_engine and rle_glyph_span_decoder
// no dependencies
package rgsd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BUF_W      = 16;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned ACC_W      = 12;
  localparam int unsigned ACC_MAX    = 4095;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned ORG_W      = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned MAX_RUN_BITS = 8;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = 1;
  localparam int unsigned QCNT_W     = 2;

  // register index map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RUN_BITS       = 3'd0,
    REG_GLYPH_WIDTH    = 3'd1,
    REG_GLYPH_HEIGHT   = 3'd2,
    REG_FIRST_POLARITY = 3'd3,
    REG_ORIGIN_X       = 3'd4,
    REG_ORIGIN_Y       = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIELD,
    ST_RUN,
    ST_FLUSH
  } eng_st_e;

  typedef struct packed {
    logic [3:0]       run_bits;
    logic [6:0]       glyph_width;
    logic [5:0]       glyph_height;
    logic             first_polarity;
    logic [ORG_W-1:0] origin_x;
    logic [ORG_W-1:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [LEN_W-1:0] len;
    logic             last;
  } span_t;

endpackage

// ===== hdl/rgsd_front.sv =====
// rgsd_front: input side, a two-entry byte queue in front of the decode engine
// depends on rgsd_pkg
module rgsd_front
  import rgsd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  output logic              byte_vld_o,
  output logic [BYTE_W-1:0] byte_o,
  input  logic              byte_pop_i
);

  logic [BYTE_W-1:0] mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign in_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign byte_vld_o = (cnt_q != '0);
  assign byte_o     = mem_q[rd_ptr_q];
  assign push       = in_valid_i & in_ready_o;
  assign pop        = byte_pop_i & byte_vld_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_byte_i;
    end
  end

endmodule

// ===== hdl/rgsd_engine.sv =====
// rgsd_engine: back end, unpacks run fields and cuts lit runs into row spans
// depends on rgsd_pkg
module rgsd_engine
  import rgsd_pkg::*;
#(
  parameter int unsigned MAX_GLYPH_WIDTH  = 64,
  parameter int unsigned MAX_GLYPH_HEIGHT = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              cfg_wr_i,
  input  logic              byte_vld_i,
  input  logic [BYTE_W-1:0] byte_i,
  output logic              byte_pop_o,
  output logic              span_vld_o,
  output span_t             span_o,
  input  logic              span_rdy_i
);

  localparam int unsigned COL_W = (MAX_GLYPH_WIDTH > 1) ? $clog2(MAX_GLYPH_WIDTH) : 1;
  localparam int unsigned W_W   = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int unsigned ROW_W = (MAX_GLYPH_HEIGHT > 1) ? $clog2(MAX_GLYPH_HEIGHT) : 1;
  localparam int unsigned H_W   = $clog2(MAX_GLYPH_HEIGHT + 1);
  localparam int unsigned RI_W  = ROW_W + 1;

  eng_st_e           st_q, st_d;
  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              on_q, on_d;
  logic              run_on_q, run_on_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-1:0]  len_q, len_d;
  logic              done_q, done_d;
  logic              rearm_q, rearm_d;
  span_t             pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;

  logic [3:0]        bits_eff;
  logic [W_W-1:0]    w_eff;
  logic [H_W-1:0]    h_eff;
  logic              raw;
  logic [7:0]        mask;
  logic [7:0]        field;
  logic              field_full;
  logic              avail;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_sat;
  logic [W_W-1:0]    seg_room;
  logic              seg_wrap;
  logic [LEN_W-1:0]  seg_len;
  logic [RI_W-1:0]   row_inc;
  logic              last_row;
  logic              emit_seg;
  logic              stall;
  logic              arm;
  span_t             seg;

  // effective header, oversize values clamp
  always_comb begin
    bits_eff = (cfg_i.run_bits > 4'(MAX_RUN_BITS)) ? 4'(MAX_RUN_BITS) : cfg_i.run_bits;
    w_eff    = (cfg_i.glyph_width > 7'(MAX_GLYPH_WIDTH)) ? W_W'(MAX_GLYPH_WIDTH)
                                                         : W_W'(cfg_i.glyph_width);
    h_eff    = (cfg_i.glyph_height > 6'(MAX_GLYPH_HEIGHT)) ? H_W'(MAX_GLYPH_HEIGHT)
                                                           : H_W'(cfg_i.glyph_height);
    raw      = (bits_eff == 4'd1);
    mask     = 8'((9'd1 << bits_eff) - 9'd1);
    field    = buf_q[7:0] & mask;
    field_full = (field == mask);
    avail    = raw ? (cnt_q != '0) : (cnt_q >= CNT_W'(bits_eff));
    // an all-ones field adds the mask, any other field adds its value plus one
    acc_sum  = (ACC_W+1)'(acc_q) + (ACC_W+1)'(field)
             + (field_full ? (ACC_W+1)'(0) : (ACC_W+1)'(1));
    acc_sat  = (acc_sum > (ACC_W+1)'(ACC_MAX)) ? ACC_W'(ACC_MAX) : acc_sum[ACC_W-1:0];
  end

  // one row segment of the current run
  always_comb begin
    seg_room = w_eff - W_W'(col_q);
    seg_wrap = (len_q >= ACC_W'(seg_room));
    seg_len  = seg_wrap ? LEN_W'(seg_room) : LEN_W'(len_q);
    row_inc  = RI_W'(row_q) + RI_W'(1);
    last_row = (row_inc >= RI_W'(h_eff));
    seg.x    = {cfg_i.origin_x[ORG_W-1], cfg_i.origin_x} + POS_W'(col_q);
    seg.y    = {cfg_i.origin_y[ORG_W-1], cfg_i.origin_y} + POS_W'(row_q);
    seg.len  = seg_len;
    seg.last = 1'b0;
  end

  assign arm      = (st_q == ST_IDLE) && rearm_q;
  assign emit_seg = (st_q == ST_RUN) && run_on_q;
  assign stall    = emit_seg && pend_vld_q && !span_rdy_i;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (!rearm_q && byte_vld_i && !done_q) begin
          st_d = ST_FIELD;
        end
      end
      ST_FIELD: begin
        if (done_q || !avail) begin
          st_d = ST_FLUSH;
        end else if (raw || !field_full) begin
          st_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stall && (!seg_wrap || last_row || (len_q == ACC_W'(seg_room)))) begin
          st_d = ST_FIELD;
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q || span_rdy_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    byte_pop_o = (st_q == ST_IDLE) && !rearm_q && byte_vld_i;
    span_vld_o = pend_vld_q && (emit_seg || (st_q == ST_FLUSH));
    span_o      = pend_q;
    span_o.last = (st_q == ST_FLUSH);
  end

  // datapath
  always_comb begin
    buf_d      = buf_q;
    cnt_d      = cnt_q;
    col_d      = col_q;
    row_d      = row_q;
    on_d       = on_q;
    run_on_d   = run_on_q;
    acc_d      = acc_q;
    len_d      = len_q;
    done_d     = done_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    rearm_d    = cfg_wr_i | (rearm_q & (st_q != ST_IDLE));
    if (arm) begin
      buf_d  = '0;
      cnt_d  = '0;
      col_d  = '0;
      row_d  = '0;
      acc_d  = '0;
      on_d   = cfg_i.first_polarity;
      done_d = (bits_eff == '0) || (w_eff == '0) || (h_eff == '0);
    end else begin
      case (st_q)
        ST_IDLE: begin
          if (byte_vld_i && !done_q) begin
            buf_d = buf_q | (BUF_W'(byte_i) << cnt_q[3:0]);
            cnt_d = cnt_q + CNT_W'(BYTE_W);
          end
        end
        ST_FIELD: begin
          if (!done_q && avail) begin
            if (raw) begin
              buf_d    = buf_q >> 1;
              cnt_d    = cnt_q - CNT_W'(1);
              on_d     = buf_q[0];
              run_on_d = buf_q[0];
              len_d    = ACC_W'(1);
            end else begin
              buf_d = buf_q >> bits_eff;
              cnt_d = cnt_q - CNT_W'(bits_eff);
              if (field_full) begin
                // all-ones field continues the run
                acc_d = acc_sat;
              end else begin
                len_d    = acc_sat;
                run_on_d = on_q;
                on_d     = !on_q;
                acc_d    = '0;
              end
            end
          end
        end
        ST_RUN: begin
          if (!stall) begin
            if (emit_seg) begin
              pend_d     = seg;
              pend_vld_d = 1'b1;
            end
            if (seg_wrap) begin
              len_d = len_q - ACC_W'(seg_room);
              col_d = '0;
              row_d = row_inc[ROW_W-1:0];
              if (last_row) begin
                done_d = 1'b1;
              end
            end else begin
              len_d = '0;
              col_d = col_q + COL_W'(len_q);
            end
          end
        end
        ST_FLUSH: begin
          if (span_rdy_i) begin
            pend_vld_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      buf_q      <= '0;
      cnt_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
      on_q       <= 1'b0;
      acc_q      <= '0;
      done_q     <= 1'b0;
      rearm_q    <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      st_q       <= st_d;
      buf_q      <= buf_d;
      cnt_q      <= cnt_d;
      col_q      <= col_d;
      row_q      <= row_d;
      on_q       <= on_d;
      acc_q      <= acc_d;
      done_q     <= done_d;
      rearm_q    <= rearm_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_on_q <= run_on_d;
    len_q    <= len_d;
    pend_q   <= pend_d;
  end

endmodule

// ===== hdl/rle_glyph_span_decoder.sv =====
// rle_glyph_span_decoder: top level, header registers, byte queue, engine, span output stage
// depends on rgsd_pkg, rgsd_front, rgsd_engine
//
// usage
// - load the glyph header on the cfg channel (index 0..5: run_bits, glyph_width,
//   glyph_height, first_polarity, origin_x, origin_y); a write to index 0..5 re-arms
//   the decoder for a new glyph, indexes 6 and 7 are dropped; cfg_ready_o is always high
// - feed compressed bytes on in_*; each item is one byte, read lsb first
// - every lit row segment comes out on out_* as x, y, length; last_span marks the
//   final span caused by one byte, a byte that lights nothing gives no item
// - byte queue: a two-entry byte queue takes bytes while the engine works; the engine
//   takes one byte at a time in ST_IDLE, steps through ST_FIELD for each run field and
//   ST_RUN for each row segment of each run, then ST_FLUSH; in raw one-bit mode each
//   pixel is its own run; a byte that arrives after the glyph is finished is popped
//   and dropped
// - a span is held back in a pending register so the last marker can be set; it
//   passes to the output register when the engine cuts the next span of the byte or
//   reaches ST_FLUSH
// - a full output register with out_ready_i low stalls the engine; the queue keeps
//   taking bytes until both entries are used
// - reset loads the header defaults (raw mode, 8x8, origin 0) and puts the engine at the start of a glyph
module rle_glyph_span_decoder
  import rgsd_pkg::*;
#(
  parameter int unsigned MAX_GLYPH_WIDTH  = 64,
  parameter int unsigned MAX_GLYPH_HEIGHT = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // byte stream
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [BYTE_W-1:0]       data_byte_i,
  // span stream
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [POS_W-1:0] span_x_o,
  output logic signed [POS_W-1:0] span_y_o,
  output logic [LEN_W-1:0]        span_length_o,
  output logic                    last_span_o
);

  cfg_t              cfg_q, cfg_d;
  logic              cfg_wr;
  logic              byte_vld;
  logic [BYTE_W-1:0] byte_data;
  logic              byte_pop;
  logic              span_vld;
  logic              span_rdy;
  span_t             span;
  span_t             out_q;
  logic              out_vld_q, out_vld_d;

  // header registers, always writable
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RUN_BITS:       cfg_d.run_bits       = cfg_data_i[3:0];
        REG_GLYPH_WIDTH:    cfg_d.glyph_width    = cfg_data_i[6:0];
        REG_GLYPH_HEIGHT:   cfg_d.glyph_height   = cfg_data_i[5:0];
        REG_FIRST_POLARITY: cfg_d.first_polarity = cfg_data_i[0];
        REG_ORIGIN_X:       cfg_d.origin_x       = cfg_data_i[ORG_W-1:0];
        REG_ORIGIN_Y:       cfg_d.origin_y       = cfg_data_i[ORG_W-1:0];
        default: ;
      endcase
    end
  end

  // an index beyond the register list does not re-arm
  logic cfg_known;
  assign cfg_known = cfg_wr && (cfg_index_i <= CFG_IDX_W'(REG_ORIGIN_Y));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_bits       <= 4'd1;
      cfg_q.glyph_width    <= 7'd8;
      cfg_q.glyph_height   <= 6'd8;
      cfg_q.first_polarity <= 1'b0;
      cfg_q.origin_x       <= '0;
      cfg_q.origin_y       <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front end: byte queue
  rgsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .byte_vld_o  (byte_vld),
    .byte_o      (byte_data),
    .byte_pop_i  (byte_pop)
  );

  // back end: field unpacking and span cutting
  rgsd_engine #(
    .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cfg_wr_i   (cfg_known),
    .byte_vld_i (byte_vld),
    .byte_i     (byte_data),
    .byte_pop_o (byte_pop),
    .span_vld_o (span_vld),
    .span_o     (span),
    .span_rdy_i (span_rdy)
  );

  // output register, refilled in the cycle it drains
  assign span_rdy = !out_vld_q || out_ready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (span_rdy) begin
      out_vld_d = span_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (span_rdy && span_vld) begin
      out_q <= span;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign span_x_o      = out_q.x;
  assign span_y_o      = out_q.y;
  assign span_length_o = out_q.len;
  assign last_span_o   = out_q.last;

`ifndef SYNTHESIS
  // a span never covers zero pixels or more than MAX_GLYPH_WIDTH pixels
  a_span_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.len != '0) && (out_q.len <= LEN_W'(MAX_GLYPH_WIDTH)))
    else $error("span length out of range");

  // the engine holds an offered span until the output stage takes it
  a_eng_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_vld && !span_rdy |=> span_vld && $stable(span))
    else $error("engine dropped or changed a stalled span");

  // the output stage only loads when empty or draining
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> out_vld_q && $stable(out_q))
    else $error("output register overwritten while stalled");
`endif

endmodule
